### hdl/sdi_pkg.sv
// Shared types, codes and frame helpers for the SD card SPI-mode bring-up sequencer.
package sdi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE            = 4'd0,
    PH_WAKE            = 4'd1,
    PH_READY_PRE       = 4'd2,
    PH_READY_POLL      = 4'd3,
    PH_FRAME           = 4'd4,
    PH_RESP            = 4'd5,
    PH_DATA            = 4'd6,
    PH_DESEL_IDLE_OK   = 4'd7,
    PH_DESEL_IDLE_FAIL = 4'd8,
    PH_DESEL_TO_OP     = 4'd9,
    PH_DESEL_ECHO_BAD  = 4'd10,
    PH_DESEL_OCR_FAIL  = 4'd11,
    PH_DESEL_OCR_DONE  = 4'd12,
    PH_DONE            = 4'd13
  } phase_e;

  localparam logic [5:0] CMD_RESET       = 6'd0;
  localparam logic [5:0] CMD_SEND_IF     = 6'd8;
  localparam logic [5:0] CMD_SD_OP_COND  = 6'd41;
  localparam logic [5:0] CMD_APP         = 6'd55;
  localparam logic [5:0] CMD_OCR         = 6'd58;

  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_NO_IDLE     = 3'd1;
  localparam logic [2:0] ERR_BAD_ECHO    = 3'd2;
  localparam logic [2:0] ERR_OP_TIMEOUT  = 3'd3;
  localparam logic [2:0] ERR_OCR_REJECT  = 3'd4;

  localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
  localparam logic [1:0] KIND_SD1        = 2'd1;
  localparam logic [1:0] KIND_SD2        = 2'd2;
  localparam logic [1:0] KIND_SDHC       = 2'd3;

  localparam logic [1:0] REG_RESP_LIMIT  = 2'd0;
  localparam logic [1:0] REG_READY_LIMIT = 2'd1;
  localparam logic [1:0] REG_OP_LIMIT    = 2'd2;
  localparam logic [1:0] REG_IDLE_TRIES  = 2'd3;

  localparam int unsigned WAKE_COUNT     = 11;
  localparam int unsigned FRAME_LEN      = 6;
  localparam logic [1:0]  DATA_LAST      = 2'd3;
  localparam logic [7:0]  BYTE_IDLE      = 8'hFF;
  localparam logic [7:0]  CRC_GO_IDLE    = 8'h95;
  localparam logic [7:0]  CRC_SEND_IF    = 8'h87;
  localparam logic [7:0]  ECHO_PATTERN   = 8'hAA;
  localparam logic [7:0]  OCR_CCS_MASK   = 8'hC0;
  localparam logic [7:0]  R1_IDLE        = 8'h01;
  localparam logic [31:0] ARG_IF_COND    = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS        = 32'h4000_0000;

  typedef struct packed {
    logic [15:0] resp_limit;
    logic [16:0] ready_limit;
    logic [13:0] op_limit;
    logic [2:0]  idle_tries;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  idle_left;
    logic [13:0] op_attempt;
    logic [1:0]  kind;
    logic [2:0]  frame_idx;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [1:0]  resp_idx;
    logic [7:0]  first_byte;
    logic        cs;
  } state_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic [1:0] card_kind;
    logic       finished;
    logic       fast_clock;
    logic       chip_select;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] cmd,
                                            input logic [31:0] arg);
    logic [7:0] b;
    case (k)
      3'd0: b = {2'b01, cmd};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      3'd5: begin
        if (cmd == CMD_RESET) b = CRC_GO_IDLE;
        else if (cmd == CMD_SEND_IF) b = CRC_SEND_IF;
        else b = BYTE_IDLE;
      end
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

### hdl/sdi_step.sv
// Next-state and result logic for one received byte or start request.
module sdi_step #(
  parameter int unsigned PW = 17
) (
  input  sdi_pkg::state_t  st_i,
  input  logic [PW-1:0]    pc_i,
  input  sdi_pkg::cfg_t    cfg_i,
  input  logic             mode_i,
  input  logic [7:0]       rx_i,
  output sdi_pkg::state_t  st_o,
  output logic [PW-1:0]    pc_o,
  output sdi_pkg::result_t res_o,
  output logic             has_res_o
);

  localparam int unsigned CW = (PW > 17) ? PW : 17;

  sdi_pkg::state_t ns;
  logic [PW-1:0]   npc;
  logic            reply_req;
  logic [7:0]      reply_val;
  logic            begin_req;
  logic [5:0]      begin_cmd;
  logic [31:0]     begin_arg;
  logic            frame_req;
  logic            send_req;
  logic [7:0]      send_byte;
  logic            send_cs;
  logic            fin_req;
  logic [2:0]      fin_err;
  logic [2:0]      fidx;

  always_comb begin
    ns        = st_i;
    npc       = pc_i;
    reply_req = 1'b0;
    reply_val = sdi_pkg::BYTE_IDLE;
    begin_req = 1'b0;
    begin_cmd = sdi_pkg::CMD_RESET;
    begin_arg = '0;
    frame_req = 1'b0;
    send_req  = 1'b0;
    send_byte = sdi_pkg::BYTE_IDLE;
    send_cs   = 1'b0;
    fin_req   = 1'b0;
    fin_err   = sdi_pkg::ERR_OK;
    fidx      = st_i.frame_idx + 3'd1;

    if (!mode_i) begin
      ns.kind       = sdi_pkg::KIND_UNKNOWN;
      ns.op_attempt = '0;
      ns.idle_left  = cfg_i.idle_tries;
      ns.phase      = sdi_pkg::PH_WAKE;
      npc           = '0;
      send_req      = 1'b1;
    end else begin
      case (st_i.phase)
        sdi_pkg::PH_WAKE: begin
          npc = pc_i + PW'(1);
          if (npc < PW'(sdi_pkg::WAKE_COUNT)) begin
            send_req = 1'b1;
          end else begin
            ns.idle_left = st_i.idle_left - 3'd1;
            begin_req    = 1'b1;
          end
        end
        sdi_pkg::PH_READY_PRE: begin
          npc = '0;
          if (cfg_i.ready_limit == '0) begin
            frame_req = 1'b1;
          end else begin
            ns.phase = sdi_pkg::PH_READY_POLL;
            send_req = 1'b1;
            send_cs  = 1'b1;
          end
        end
        sdi_pkg::PH_READY_POLL: begin
          if (rx_i == sdi_pkg::BYTE_IDLE) begin
            frame_req = 1'b1;
          end else begin
            npc = pc_i + PW'(1);
            if (CW'(npc) >= CW'(cfg_i.ready_limit)) begin
              frame_req = 1'b1;
            end else begin
              send_req = 1'b1;
              send_cs  = 1'b1;
            end
          end
        end
        sdi_pkg::PH_FRAME: begin
          ns.frame_idx = fidx;
          if (fidx < 3'(sdi_pkg::FRAME_LEN)) begin
            send_req  = 1'b1;
            send_cs   = 1'b1;
            send_byte = sdi_pkg::frame_byte(fidx, st_i.cmd, st_i.arg);
          end else begin
            npc = '0;
            if (cfg_i.resp_limit == '0) begin
              reply_req = 1'b1;
            end else begin
              ns.phase = sdi_pkg::PH_RESP;
              send_req = 1'b1;
              send_cs  = 1'b1;
            end
          end
        end
        sdi_pkg::PH_RESP: begin
          reply_val = rx_i;
          if (!rx_i[7]) begin
            reply_req = 1'b1;
          end else begin
            npc = pc_i + PW'(1);
            if (CW'(npc) >= CW'(cfg_i.resp_limit)) begin
              reply_req = 1'b1;
            end else begin
              send_req = 1'b1;
              send_cs  = 1'b1;
            end
          end
        end
        sdi_pkg::PH_DATA: begin
          if (st_i.resp_idx == 2'd0) ns.first_byte = rx_i;
          send_req = 1'b1;
          if (st_i.resp_idx != sdi_pkg::DATA_LAST) begin
            ns.resp_idx = st_i.resp_idx + 2'd1;
            send_cs     = 1'b1;
          end else if (st_i.cmd == sdi_pkg::CMD_SEND_IF) begin
            if (rx_i == sdi_pkg::ECHO_PATTERN) begin
              ns.kind  = sdi_pkg::KIND_SD2;
              ns.phase = sdi_pkg::PH_DESEL_TO_OP;
            end else begin
              ns.phase = sdi_pkg::PH_DESEL_ECHO_BAD;
            end
          end else begin
            if ((ns.first_byte & sdi_pkg::OCR_CCS_MASK) == sdi_pkg::OCR_CCS_MASK) begin
              ns.kind = sdi_pkg::KIND_SDHC;
            end
            ns.phase = sdi_pkg::PH_DESEL_OCR_DONE;
          end
        end
        sdi_pkg::PH_DESEL_IDLE_OK: begin
          begin_req = 1'b1;
          begin_cmd = sdi_pkg::CMD_SEND_IF;
          begin_arg = sdi_pkg::ARG_IF_COND;
        end
        sdi_pkg::PH_DESEL_IDLE_FAIL: begin
          fin_req = 1'b1;
          fin_err = sdi_pkg::ERR_NO_IDLE;
        end
        sdi_pkg::PH_DESEL_TO_OP: begin
          ns.op_attempt = '0;
          begin_req     = 1'b1;
          begin_cmd     = sdi_pkg::CMD_APP;
        end
        sdi_pkg::PH_DESEL_ECHO_BAD: begin
          fin_req = 1'b1;
          fin_err = sdi_pkg::ERR_BAD_ECHO;
        end
        sdi_pkg::PH_DESEL_OCR_FAIL: begin
          fin_req = 1'b1;
          fin_err = sdi_pkg::ERR_OCR_REJECT;
        end
        sdi_pkg::PH_DESEL_OCR_DONE: begin
          fin_req = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // resolve the command reply
    if (reply_req) begin
      case (st_i.cmd)
        sdi_pkg::CMD_RESET: begin
          send_req = 1'b1;
          if (reply_val == sdi_pkg::R1_IDLE) begin
            ns.phase = sdi_pkg::PH_DESEL_IDLE_OK;
          end else if (ns.idle_left == 3'd0) begin
            ns.phase = sdi_pkg::PH_DESEL_IDLE_FAIL;
          end else begin
            ns.phase = sdi_pkg::PH_WAKE;
            npc      = '0;
          end
        end
        sdi_pkg::CMD_SEND_IF: begin
          send_req = 1'b1;
          if (reply_val[2]) begin
            ns.kind  = sdi_pkg::KIND_SD1;
            ns.phase = sdi_pkg::PH_DESEL_TO_OP;
          end else begin
            ns.resp_idx = 2'd0;
            ns.phase    = sdi_pkg::PH_DATA;
            send_cs     = 1'b1;
          end
        end
        sdi_pkg::CMD_APP: begin
          begin_req = 1'b1;
          begin_cmd = sdi_pkg::CMD_SD_OP_COND;
          begin_arg = (ns.kind == sdi_pkg::KIND_SD2) ? sdi_pkg::ARG_HCS : '0;
        end
        sdi_pkg::CMD_SD_OP_COND: begin
          if (reply_val == 8'd0) begin
            if (ns.kind == sdi_pkg::KIND_SD2) begin
              begin_req = 1'b1;
              begin_cmd = sdi_pkg::CMD_OCR;
            end else begin
              fin_req = 1'b1;
            end
          end else if (st_i.op_attempt >= cfg_i.op_limit) begin
            fin_req = 1'b1;
            fin_err = sdi_pkg::ERR_OP_TIMEOUT;
          end else begin
            ns.op_attempt = st_i.op_attempt + 14'd1;
            begin_req     = 1'b1;
            begin_cmd     = sdi_pkg::CMD_APP;
          end
        end
        sdi_pkg::CMD_OCR: begin
          send_req = 1'b1;
          if (reply_val != 8'd0) begin
            ns.phase = sdi_pkg::PH_DESEL_OCR_FAIL;
          end else begin
            ns.resp_idx = 2'd0;
            ns.phase    = sdi_pkg::PH_DATA;
            send_cs     = 1'b1;
          end
        end
        default: begin
          fin_req = 1'b1;
        end
      endcase
    end

    // open the next command
    if (begin_req) begin
      ns.cmd = begin_cmd;
      ns.arg = begin_arg;
      if (begin_cmd == sdi_pkg::CMD_RESET) begin
        frame_req = 1'b1;
      end else begin
        ns.phase = sdi_pkg::PH_READY_PRE;
        send_req = 1'b1;
        send_cs  = 1'b1;
      end
    end

    if (frame_req) begin
      ns.frame_idx = 3'd0;
      ns.phase     = sdi_pkg::PH_FRAME;
      send_req     = 1'b1;
      send_cs      = 1'b1;
      send_byte    = sdi_pkg::frame_byte(3'd0, ns.cmd, ns.arg);
    end

    res_o     = '0;
    has_res_o = send_req | fin_req;
    if (fin_req) begin
      ns.phase          = sdi_pkg::PH_DONE;
      res_o.chip_select = st_i.cs;
      res_o.fast_clock  = (fin_err == sdi_pkg::ERR_OK);
      res_o.finished    = 1'b1;
      res_o.card_kind   = ns.kind;
      res_o.error_code  = fin_err;
    end else if (send_req) begin
      ns.cs             = send_cs;
      res_o.tx_valid    = 1'b1;
      res_o.tx_byte     = send_byte;
      res_o.chip_select = send_cs;
    end

    st_o = ns;
    pc_o = npc;
  end

endmodule

### hdl/sd_spi_card_init_sequencer_top.sv
// Top level of the SD card SPI-mode bring-up sequencer: ports, registers and handshake.
// Each input transfer is a start request (tuser high is a received byte, low is start) or the
// byte the card returned during the previous exchange; each result asks for the next byte
// exchange or reports the end of bring-up with card kind and error code. The block takes one
// item per clock whenever the output side keeps up: an item is held in the input register,
// the sequencer step logic works on it combinationally and its result lands in the output
// register. A received byte while idle or finished gives no result.
// Write the limits only while idle.
module sd_spi_card_init_sequencer_top #(
  parameter int unsigned POLL_COUNT_WIDTH = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] tx_valid, [8:1] tx_byte, [9] chip_select, [10] fast_clock, [11] finished,
  // [13:12] card_kind, [16:14] error_code, [23:17] zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned PW = POLL_COUNT_WIDTH;

  sdi_pkg::cfg_t    cfg_q, cfg_d;
  sdi_pkg::state_t  st_q, st_d;
  logic [PW-1:0]    pc_q, pc_d;
  logic             in_valid_q, in_valid_d;
  logic             in_mode_q, in_mode_d;
  logic [7:0]       in_rx_q, in_rx_d;
  logic             out_valid_q, out_valid_d;
  sdi_pkg::result_t out_q, out_d;
  sdi_pkg::result_t res;
  logic             has_res;
  logic             advance;

  sdi_step #(.PW(PW)) u_step (
    .st_i      (st_q),
    .pc_i      (pc_q),
    .cfg_i     (cfg_q),
    .mode_i    (in_mode_q),
    .rx_i      (in_rx_q),
    .st_o      (st_d),
    .pc_o      (pc_d),
    .res_o     (res),
    .has_res_o (has_res)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sdi_pkg::REG_RESP_LIMIT:  cfg_d.resp_limit  = cfg_data_i[15:0];
        sdi_pkg::REG_READY_LIMIT: cfg_d.ready_limit = cfg_data_i;
        sdi_pkg::REG_OP_LIMIT:    cfg_d.op_limit    = cfg_data_i[13:0];
        sdi_pkg::REG_IDLE_TRIES:  cfg_d.idle_tries  = cfg_data_i[2:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    in_mode_d  = in_mode_q;
    in_rx_d    = in_rx_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
      in_mode_d  = s_axis_tuser_i;
      in_rx_d    = s_axis_tdata_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (advance && has_res) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{resp_limit: 16'd7000, ready_limit: 17'd100000,
                       op_limit: 14'd8000, idle_tries: 3'd4};
      st_q        <= '0;
      pc_q        <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q <= st_d;
        pc_q <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_mode_q <= in_mode_d;
    in_rx_q   <= in_rx_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.error_code, out_q.card_kind, out_q.finished,
                            out_q.fast_clock, out_q.chip_select, out_q.tx_byte,
                            out_q.tx_valid};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q)
    else $error("input stalled without a held item");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == sdi_pkg::PH_FRAME |-> st_q.frame_idx < 3'(sdi_pkg::FRAME_LEN))
    else $error("frame index out of range");

  a_data_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == sdi_pkg::PH_DATA |->
      st_q.cmd == sdi_pkg::CMD_SEND_IF || st_q.cmd == sdi_pkg::CMD_OCR)
    else $error("trailing response bytes for wrong command");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_res && res.finished |=> st_q.phase == sdi_pkg::PH_DONE && !out_q.tx_valid)
    else $error("finish result without done phase");

endmodule
